>>> hw/rtl/pts_pkg.sv
// pts_pkg: shared types and codes for the periodic task scheduler
// used by pts_ctrl, pts_dp and periodic_task_scheduler
package pts_pkg;

    typedef enum logic [3:0] {
        CMD_ADD        = 4'd0,
        CMD_DELETE     = 4'd1,
        CMD_SUSPEND    = 4'd2,
        CMD_RESUME     = 4'd3,
        CMD_LOOKUP     = 4'd4,
        CMD_EXEC       = 4'd5,
        CMD_TICK       = 4'd6,
        CMD_RUNTICK    = 4'd7,
        CMD_SLEEP      = 4'd8,
        CMD_SET_PERIOD = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        SS_DETACHED  = 2'd0,
        SS_ACTIVE    = 2'd1,
        SS_SUSPENDED = 2'd2
    } slot_state_t;

    localparam logic [1:0] RS_OK   = 2'd0;
    localparam logic [1:0] RS_DUP  = 2'd1;
    localparam logic [1:0] RS_FAIL = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_RUN  = 2'd1,
        FSM_WALK = 2'd2
    } fsm_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic single_op;
        logic step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_cmd;
        logic walk_done;
        logic need_emit;
        logic finish_out;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/pts_ctrl.sv
// pts_ctrl: sequencing state machine of the periodic task scheduler
// depends on pts_pkg
module pts_ctrl
    import pts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    fsm_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_valid) state_next = FSM_RUN;
            end
            FSM_RUN: begin
                if (stat.walk_cmd) state_next = FSM_WALK;
                else if (stat.out_free) state_next = FSM_IDLE;
            end
            FSM_WALK: begin
                if (stat.walk_done && (stat.out_free || !stat.finish_out))
                    state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            FSM_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            FSM_RUN: begin
                cmd.single_op = !stat.walk_cmd && stat.out_free;
            end
            FSM_WALK: begin
                if (stat.walk_done)
                    cmd.finish = stat.out_free || !stat.finish_out;
                else
                    cmd.step = !stat.need_emit || stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/pts_dp.sv
// pts_dp: slot table, active list and result register of the scheduler
// depends on pts_pkg
module pts_dp
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int TICK_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [3:0]  in_command,
    input  logic [2:0]  in_slot,
    input  logic [15:0] in_task_id,
    input  logic [31:0] in_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic [2:0]  out_slot,
    output logic        out_slot_valid,
    output logic [31:0] out_run_time,
    output logic        out_last
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [TICK_BITS-1:0] TMAX = '1;

    // latched command word
    logic [3:0]           cmd_reg;
    logic [2:0]           slot_reg;
    logic [15:0]          id_reg;
    logic [TICK_BITS-1:0] t_reg;

    slot_state_t          st_reg  [TASK_SLOTS];
    logic [15:0]          id_mem_reg [TASK_SLOTS];
    logic [TICK_BITS-1:0] per_reg [TASK_SLOTS];
    logic [TICK_BITS-1:0] cd_reg  [TASK_SLOTS];
    logic                 rdy_reg [TASK_SLOTS];
    logic [TICK_BITS-1:0] rt_reg  [TASK_SLOTS];
    logic [TICK_BITS-1:0] cap_reg [TASK_SLOTS];
    logic [IDX_W-1:0]     ord_reg [TASK_SLOTS];
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     le_reg;
    logic                 lev_reg;
    logic [CNT_W-1:0]     k_reg;
    logic                 emitted_reg;

    logic                 ov_reg;
    logic [1:0]           o_status_reg;
    logic [2:0]           o_slot_reg;
    logic                 o_sv_reg;
    logic [31:0]          o_rt_reg;
    logic                 o_last_reg;

    logic [IDX_W-1:0]     ord_next [TASK_SLOTS];
    logic [IDX_W-1:0]     ord_rm   [TASK_SLOTS];
    logic [CNT_W-1:0]     cnt_next;

    logic [IDX_W-1:0]     sidx;
    logic                 slot_ok;
    logic [15:0]          key;
    logic [TASK_SLOTS-1:0] act_m, sus_m;
    logic                 f_hit, r_hit, in_list, later_ready;
    logic [IDX_W-1:0]     f_idx, r_idx, target, a_idx;
    logic [IDX_W-1:0]     rm_pos;
    logic                 out_free;

    // single command decode
    logic [1:0]           res_status;
    logic                 res_sv;
    logic [IDX_W-1:0]     res_slot;
    logic [TICK_BITS-1:0] res_rt;
    logic                 wr_fields, clr_en, st_wr_en, rm_en, push_en, sleep_en, per_en;
    logic [IDX_W-1:0]     clr_idx, st_wr_idx, push_idx;
    slot_state_t          st_wr_val, st1;
    logic                 hit_a, hit_b, susp_hit, act_hit;

    assign sidx     = IDX_W'(slot_reg);
    assign slot_ok  = 32'(slot_reg) < TASK_SLOTS;
    assign key      = (cmd_reg == CMD_DELETE) ? id_mem_reg[sidx] : id_reg;
    assign a_idx    = ord_reg[k_reg[IDX_W-1:0]];
    assign out_free = !ov_reg || out_ready;

    always_comb begin
        act_m = '0;
        sus_m = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            act_m[i] = (st_reg[i] == SS_ACTIVE) && (id_mem_reg[i] == key);
            sus_m[i] = (st_reg[i] == SS_SUSPENDED) && (id_mem_reg[i] == key);
        end
    end

    // first active slot in list order, first suspended slot by index
    always_comb begin
        f_hit = 1'b0;
        f_idx = '0;
        r_hit = 1'b0;
        r_idx = '0;
        for (int p = 0; p < TASK_SLOTS; p++) begin
            if (!f_hit && p < int'(cnt_reg) && id_mem_reg[ord_reg[p]] == key) begin
                f_hit = 1'b1;
                f_idx = ord_reg[p];
            end
            if (!r_hit && sus_m[p]) begin
                r_hit = 1'b1;
                r_idx = IDX_W'(p);
            end
        end
    end

    assign target = (cmd_reg == CMD_SUSPEND) ? f_idx : sidx;

    always_comb begin
        in_list     = 1'b0;
        rm_pos      = '0;
        later_ready = 1'b0;
        for (int p = 0; p < TASK_SLOTS; p++) begin
            if (!in_list && p < int'(cnt_reg) && ord_reg[p] == target) begin
                in_list = 1'b1;
                rm_pos  = IDX_W'(p);
            end
            if (p > int'(k_reg) && p < int'(cnt_reg) && rdy_reg[ord_reg[p]])
                later_ready = 1'b1;
        end
    end

    always_comb begin
        res_status = RS_OK;
        res_sv     = 1'b0;
        res_slot   = '0;
        res_rt     = '0;
        wr_fields  = 1'b0;
        clr_en     = 1'b0;
        clr_idx    = sidx;
        st_wr_en   = 1'b0;
        st_wr_idx  = sidx;
        st_wr_val  = SS_DETACHED;
        rm_en      = 1'b0;
        push_en    = 1'b0;
        push_idx   = sidx;
        sleep_en   = 1'b0;
        per_en     = 1'b0;
        st1        = st_reg[sidx];
        hit_a      = 1'b0;
        hit_b      = 1'b0;
        susp_hit   = 1'b0;
        act_hit    = 1'b0;
        case (cmd_reg)
            CMD_ADD: begin
                if (!slot_ok) begin
                    res_status = RS_FAIL;
                end else begin
                    wr_fields = 1'b1;
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (i != int'(sidx) && sus_m[i]) susp_hit = 1'b1;
                    if (st_reg[sidx] == SS_SUSPENDED) susp_hit = 1'b1;
                    st1 = susp_hit ? SS_DETACHED : st_reg[sidx];
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (i != int'(sidx) && act_m[i]) act_hit = 1'b1;
                    if (st1 == SS_ACTIVE) act_hit = 1'b1;
                    rm_en     = susp_hit && st_reg[sidx] == SS_ACTIVE;
                    st_wr_en  = 1'b1;
                    st_wr_val = act_hit ? st1 : SS_ACTIVE;
                    push_en   = !act_hit;
                    if (act_hit) res_status = RS_DUP;
                end
            end
            CMD_DELETE: begin
                if (!slot_ok) begin
                    res_status = RS_FAIL;
                end else begin
                    hit_a  = |act_m;
                    clr_en = hit_a;
                    st1    = hit_a ? SS_DETACHED : st_reg[sidx];
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (i != int'(sidx) && sus_m[i]) hit_b = 1'b1;
                    if (st1 == SS_SUSPENDED) hit_b = 1'b1;
                    st_wr_en = 1'b1;
                    if (hit_b) begin
                        res_status = RS_FAIL;
                        st_wr_val  = st1;
                        rm_en      = hit_a && st_reg[sidx] == SS_ACTIVE;
                    end else begin
                        st_wr_val = SS_SUSPENDED;
                        rm_en     = st_reg[sidx] == SS_ACTIVE;
                    end
                end
            end
            CMD_SUSPEND: begin
                if (!f_hit) begin
                    res_status = RS_FAIL;
                end else begin
                    clr_en    = 1'b1;
                    clr_idx   = f_idx;
                    rm_en     = in_list;
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (i != int'(f_idx) && sus_m[i]) hit_b = 1'b1;
                    st_wr_en  = 1'b1;
                    st_wr_idx = f_idx;
                    st_wr_val = hit_b ? SS_DETACHED : SS_SUSPENDED;
                    if (hit_b) res_status = RS_FAIL;
                end
            end
            CMD_RESUME: begin
                if (!r_hit) begin
                    res_status = RS_FAIL;
                end else begin
                    clr_en    = 1'b1;
                    clr_idx   = r_idx;
                    act_hit   = |act_m;
                    st_wr_en  = 1'b1;
                    st_wr_idx = r_idx;
                    st_wr_val = act_hit ? SS_DETACHED : SS_ACTIVE;
                    push_en   = !act_hit;
                    push_idx  = r_idx;
                    if (act_hit) res_status = RS_FAIL;
                end
            end
            CMD_LOOKUP: begin
                if (!f_hit) begin
                    res_status = RS_FAIL;
                end else begin
                    res_sv   = 1'b1;
                    res_slot = f_idx;
                    res_rt   = cap_reg[f_idx];
                end
            end
            CMD_SLEEP: begin
                if (lev_reg) sleep_en = 1'b1;
                else res_status = RS_FAIL;
            end
            CMD_SET_PERIOD: begin
                if (slot_ok) per_en = 1'b1;
                else res_status = RS_FAIL;
            end
            default: res_status = RS_FAIL;
        endcase
    end

    // remove from list, then push at head
    always_comb begin
        ord_rm = ord_reg;
        if (rm_en) begin
            for (int p = 0; p < TASK_SLOTS - 1; p++)
                if (p >= int'(rm_pos)) ord_rm[p] = ord_reg[p + 1];
        end
        ord_next = ord_rm;
        if (push_en) begin
            ord_next[0] = push_idx;
            for (int p = 1; p < TASK_SLOTS; p++) ord_next[p] = ord_rm[p - 1];
        end
        cnt_next = cnt_reg - CNT_W'(rm_en) + CNT_W'(push_en);
    end

    logic is_walk;
    assign is_walk = cmd_reg == CMD_TICK || cmd_reg == CMD_RUNTICK || cmd_reg == CMD_EXEC;

    assign stat.walk_cmd   = is_walk;
    assign stat.walk_done  = k_reg >= cnt_reg;
    assign stat.need_emit  = cmd_reg == CMD_EXEC && rdy_reg[a_idx];
    assign stat.finish_out = !(cmd_reg == CMD_EXEC && emitted_reg);
    assign stat.out_free   = out_free;

    logic load_out;
    assign load_out = cmd.single_op || (cmd.finish && stat.finish_out)
                      || (cmd.step && stat.need_emit);

    // control state and reset-cleared tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                st_reg[i]  <= SS_DETACHED;
                per_reg[i] <= '0;
                rdy_reg[i] <= 1'b0;
            end
            cnt_reg     <= '0;
            lev_reg     <= 1'b0;
            k_reg       <= '0;
            emitted_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            if (load_out) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (cmd.accept) begin
                k_reg       <= '0;
                emitted_reg <= 1'b0;
            end
            if (cmd.single_op) begin
                cnt_reg <= cnt_next;
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (wr_fields && i == int'(sidx)) begin
                        rdy_reg[i] <= 1'b0;
                        per_reg[i] <= t_reg;
                    end
                    if (clr_en && i == int'(clr_idx)) rdy_reg[i] <= 1'b0;
                    if (st_wr_en && i == int'(st_wr_idx)) st_reg[i] <= st_wr_val;
                    if (per_en && i == int'(sidx)) per_reg[i] <= t_reg;
                end
            end
            if (cmd.step) begin
                k_reg <= k_reg + 1'b1;
                case (cmd_reg)
                    CMD_TICK: begin
                        if (cd_reg[a_idx] == TICK_BITS'(1)) begin
                            rdy_reg[a_idx] <= 1'b1;
                            lev_reg        <= 1'b1;
                        end
                    end
                    CMD_EXEC: begin
                        if (rdy_reg[a_idx]) begin
                            rdy_reg[a_idx] <= 1'b0;
                            emitted_reg    <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= in_command;
            slot_reg <= in_slot;
            id_reg   <= in_task_id;
            t_reg    <= TICK_BITS'(in_ticks);
        end
        if (cmd.single_op) begin
            ord_reg <= ord_next;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (clr_en && i == int'(clr_idx)) cd_reg[i] <= per_reg[i];
                if (wr_fields && i == int'(sidx)) begin
                    id_mem_reg[i] <= id_reg;
                    cd_reg[i]     <= t_reg;
                    rt_reg[i]     <= '0;
                    cap_reg[i]    <= '0;
                end
                if (sleep_en && i == int'(le_reg)) cd_reg[i] <= t_reg;
            end
        end
        if (cmd.step) begin
            case (cmd_reg)
                CMD_TICK: begin
                    if (cd_reg[a_idx] == TICK_BITS'(1)) begin
                        cd_reg[a_idx] <= per_reg[a_idx];
                        le_reg        <= a_idx;
                    end else if (cd_reg[a_idx] != '0) begin
                        cd_reg[a_idx] <= cd_reg[a_idx] - 1'b1;
                    end
                end
                CMD_RUNTICK: begin
                    if (rdy_reg[a_idx] && rt_reg[a_idx] != TMAX)
                        rt_reg[a_idx] <= rt_reg[a_idx] + 1'b1;
                end
                CMD_EXEC: begin
                    if (rdy_reg[a_idx]) begin
                        cap_reg[a_idx] <= rt_reg[a_idx];
                        rt_reg[a_idx]  <= '0;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.single_op) begin
            o_status_reg <= res_status;
            o_slot_reg   <= 3'(res_slot);
            o_sv_reg     <= res_sv;
            o_rt_reg     <= 32'(res_rt);
            o_last_reg   <= 1'b1;
        end else if (cmd.step && stat.need_emit) begin
            o_status_reg <= RS_OK;
            o_slot_reg   <= 3'(a_idx);
            o_sv_reg     <= 1'b1;
            o_rt_reg     <= 32'(rt_reg[a_idx]);
            o_last_reg   <= !later_ready;
        end else if (cmd.finish && stat.finish_out) begin
            o_status_reg <= RS_OK;
            o_slot_reg   <= (cmd_reg == CMD_TICK && lev_reg) ? 3'(le_reg) : 3'd0;
            o_sv_reg     <= cmd_reg == CMD_TICK && lev_reg;
            o_rt_reg     <= '0;
            o_last_reg   <= 1'b1;
        end
    end

    assign out_valid      = ov_reg;
    assign out_status     = o_status_reg;
    assign out_slot       = o_slot_reg;
    assign out_slot_valid = o_sv_reg;
    assign out_run_time   = o_rt_reg;
    assign out_last       = o_last_reg;

endmodule

>>> hw/rtl/periodic_task_scheduler.sv
// Periodic task scheduler: one command word in, one or more result words out.
// Tick, runtime tick and exec walk the active list slot by slot; other commands
// are carried out as a single operation. Exec may stall on each result word
// until it is taken.
// depends on pts_pkg, pts_ctrl, pts_dp
module periodic_task_scheduler
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int TICK_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [2:0]  s_slot,
    input  logic [15:0] s_task_id,
    input  logic [31:0] s_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_slot_out,
    output logic        m_slot_valid,
    output logic [31:0] m_run_time,
    output logic        m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pts_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .TICK_BITS  (TICK_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_command     (s_command),
        .in_slot        (s_slot),
        .in_task_id     (s_task_id),
        .in_ticks       (s_ticks),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_status     (m_status),
        .out_slot       (m_slot_out),
        .out_slot_valid (m_slot_valid),
        .out_run_time   (m_run_time),
        .out_last       (m_last)
    );

endmodule

>>> tb/sv/periodic_task_scheduler_test.sv
// periodic_task_scheduler_test: self-checking testbench for the task scheduler
// keeps a shadow copy of the slot table, predicts each result word and
// compares it with the DUT output; depends on pts_pkg and periodic_task_scheduler
module periodic_task_scheduler_test
    import pts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 8;
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef struct {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic        slot_valid;
        logic [31:0] run_time;
        logic        last;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_command;
    logic [2:0]  s_slot;
    logic [15:0] s_task_id;
    logic [31:0] s_ticks;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [2:0]  m_slot_out;
    logic        m_slot_valid;
    logic [31:0] m_run_time;
    logic        m_last;

    periodic_task_scheduler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_slot(s_slot), .s_task_id(s_task_id), .s_ticks(s_ticks),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_slot_out(m_slot_out), .m_slot_valid(m_slot_valid),
        .m_run_time(m_run_time), .m_last(m_last)
    );

    // shadow slot table
    slot_state_t sh_state [NSLOTS];
    logic [15:0] sh_id [NSLOTS];
    logic [31:0] sh_period [NSLOTS];
    logic [31:0] sh_count [NSLOTS];
    logic        sh_ready [NSLOTS];
    logic [31:0] sh_runt [NSLOTS];
    logic [31:0] sh_capt [NSLOTS];
    bit          sh_written [NSLOTS];
    int          run_list[$];
    bit          expired_valid;
    int          expired_slot;

    result_t     pending_results[$];
    int          src_idle;
    int          snk_idle;
    bit          failed;
    logic [15:0] id_pool [4];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    // result word checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word st=%0d slot=%0d v=%0d rt=%0d last=%0d",
                         $time, m_status, m_slot_out, m_slot_valid, m_run_time, m_last);
                failed = 1'b1;
            end else begin
                result_t e;
                e = pending_results.pop_front();
                if (e.status !== m_status || e.slot !== m_slot_out ||
                    e.slot_valid !== m_slot_valid || e.run_time !== m_run_time ||
                    e.last !== m_last) begin
                    $display("%0t: expected st=%0d slot=%0d v=%0d rt=%0d last=%0d",
                             $time, e.status, e.slot, e.slot_valid, e.run_time, e.last);
                    $display("%0t: actual   st=%0d slot=%0d v=%0d rt=%0d last=%0d",
                             $time, m_status, m_slot_out, m_slot_valid, m_run_time,
                             m_last);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic bit id_in_state(logic [15:0] id, slot_state_t st);
        for (int i = 0; i < NSLOTS; i++)
            if (sh_state[i] == st && sh_id[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int first_running(logic [15:0] id);
        foreach (run_list[i])
            if (sh_id[run_list[i]] == id) return run_list[i];
        return -1;
    endfunction

    function automatic void unlink(int s);
        if (sh_state[s] == SS_ACTIVE)
            foreach (run_list[i])
                if (run_list[i] == s) begin
                    run_list.delete(i);
                    break;
                end
        sh_state[s] = SS_DETACHED;
    endfunction

    function automatic void link_head(int s);
        if (run_list.size() >= NSLOTS) return;
        run_list.push_front(s);
        sh_state[s] = SS_ACTIVE;
    endfunction

    function automatic void rearm(int s);
        sh_ready[s] = 1'b0;
        sh_count[s] = sh_period[s];
    endfunction

    function automatic void push_result(logic [1:0] st, int s, logic v, logic [31:0] rt,
                                        logic lst);
        result_t r;
        r.status = st;
        r.slot = s[2:0];
        r.slot_valid = v;
        r.run_time = rt;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    // updates the shadow table for one accepted command and queues its results
    function automatic void schedule_command(logic [3:0] cmd, int s, logic [15:0] id,
                                             logic [31:0] t);
        logic [1:0] st;
        int f;
        int n;
        st = RS_OK;
        case (cmd)
            CMD_ADD: begin
                sh_written[s] = 1'b1;
                sh_id[s] = id;
                sh_ready[s] = 1'b0;
                sh_count[s] = t;
                sh_period[s] = t;
                sh_runt[s] = '0;
                sh_capt[s] = '0;
                if (id_in_state(id, SS_SUSPENDED)) unlink(s);
                if (id_in_state(id, SS_ACTIVE)) st = RS_DUP;
                else link_head(s);
            end
            CMD_DELETE: begin
                if (id_in_state(sh_id[s], SS_ACTIVE)) begin
                    rearm(s);
                    unlink(s);
                end
                if (id_in_state(sh_id[s], SS_SUSPENDED)) st = RS_FAIL;
                else begin
                    unlink(s);
                    sh_state[s] = SS_SUSPENDED;
                end
            end
            CMD_SUSPEND: begin
                f = first_running(id);
                if (f < 0) st = RS_FAIL;
                else begin
                    rearm(f);
                    unlink(f);
                    if (id_in_state(id, SS_SUSPENDED)) st = RS_FAIL;
                    else sh_state[f] = SS_SUSPENDED;
                end
            end
            CMD_RESUME: begin
                st = RS_FAIL;
                for (int i = 0; i < NSLOTS; i++)
                    if (sh_state[i] == SS_SUSPENDED && sh_id[i] == id) begin
                        rearm(i);
                        unlink(i);
                        if (!id_in_state(id, SS_ACTIVE)) begin
                            link_head(i);
                            st = RS_OK;
                        end
                        break;
                    end
            end
            CMD_LOOKUP: begin
                f = first_running(id);
                if (f < 0) push_result(RS_FAIL, 0, 1'b0, '0, 1'b1);
                else push_result(RS_OK, f, 1'b1, sh_capt[f], 1'b1);
                return;
            end
            CMD_EXEC: begin
                n = 0;
                foreach (run_list[i]) begin
                    f = run_list[i];
                    if (sh_ready[f]) begin
                        sh_capt[f] = sh_runt[f];
                        sh_ready[f] = 1'b0;
                        sh_runt[f] = '0;
                        push_result(RS_OK, f, 1'b1, sh_capt[f], 1'b0);
                        n++;
                    end
                end
                if (n == 0) push_result(RS_OK, 0, 1'b0, '0, 1'b1);
                else pending_results[pending_results.size() - 1].last = 1'b1;
                return;
            end
            CMD_TICK: begin
                foreach (run_list[i]) begin
                    f = run_list[i];
                    if (sh_count[f] != 0) begin
                        sh_count[f]--;
                        if (sh_count[f] == 0) begin
                            sh_ready[f] = 1'b1;
                            expired_slot = f;
                            expired_valid = 1'b1;
                            sh_count[f] = sh_period[f];
                        end
                    end
                end
                push_result(RS_OK, expired_valid ? expired_slot : 0, expired_valid, '0,
                            1'b1);
                return;
            end
            CMD_RUNTICK: begin
                foreach (run_list[i]) begin
                    f = run_list[i];
                    if (sh_ready[f] && sh_runt[f] != '1) sh_runt[f]++;
                end
            end
            CMD_SLEEP: begin
                if (expired_valid) sh_count[expired_slot] = t;
                else st = RS_FAIL;
            end
            CMD_SET_PERIOD: sh_period[s] = t;
            default: st = RS_FAIL;
        endcase
        push_result(st, 0, 1'b0, '0, 1'b1);
    endfunction

    task automatic send_word(logic [3:0] cmd, logic [2:0] s, logic [15:0] id,
                             logic [31:0] t);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_slot <= s;
        s_task_id <= id;
        s_ticks <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        schedule_command(cmd, int'(s), id, t);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic test_directed;
        send_word(CMD_SLEEP, 3'd0, 16'h0000, 32'd5);      // nothing expired yet
        send_word(CMD_TICK, 3'd0, 16'h0000, 32'd0);       // empty list
        send_word(CMD_EXEC, 3'd0, 16'h0000, 32'd0);       // nothing ready
        send_word(CMD_ADD, 3'd0, 16'hFFFF, 32'd1);
        send_word(CMD_ADD, 3'd1, 16'hFFFF, 32'd2);        // duplicate id
        send_word(CMD_ADD, 3'd7, 16'h0000, 32'd0);        // zero period never fires
        send_word(CMD_ADD, 3'd2, 16'h1234, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 3'd0, 16'h0000, 32'd0);
        send_word(CMD_RUNTICK, 3'd0, 16'h0000, 32'd0);
        send_word(CMD_RUNTICK, 3'd0, 16'h0000, 32'd0);
        send_word(CMD_EXEC, 3'd0, 16'h0000, 32'd0);
        send_word(CMD_LOOKUP, 3'd0, 16'hFFFF, 32'd0);
        send_word(CMD_LOOKUP, 3'd0, 16'hBEEF, 32'd0);     // miss
        send_word(CMD_SLEEP, 3'd0, 16'h0000, 32'hFFFF_FFFF);
        send_word(CMD_SUSPEND, 3'd0, 16'hFFFF, 32'd0);
        send_word(CMD_SUSPEND, 3'd0, 16'hBEEF, 32'd0);    // miss
        send_word(CMD_ADD, 3'd3, 16'hFFFF, 32'd3);        // id held by a suspended slot
        send_word(CMD_RESUME, 3'd0, 16'hFFFF, 32'd0);
        send_word(CMD_RESUME, 3'd0, 16'hBEEF, 32'd0);     // miss
        send_word(CMD_DELETE, 3'd2, 16'h0000, 32'd0);
        send_word(CMD_DELETE, 3'd2, 16'h0000, 32'd0);
        send_word(CMD_SET_PERIOD, 3'd7, 16'h0000, 32'd1);
        send_word(CMD_UNUSED_HI, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_UNUSED_LO, 3'd0, 16'h0000, 32'd0);
        drain();
    endtask

    task automatic test_random(int count);
        int k;
        logic [3:0] cmd;
        logic [2:0] s;
        logic [15:0] id;
        logic [31:0] t;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            s = 3'($urandom_range(NSLOTS - 1));
            id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(3)];
            t = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4));
            if (k < 14) cmd = CMD_ADD;
            else if (k < 20) cmd = CMD_DELETE;
            else if (k < 27) cmd = CMD_SUSPEND;
            else if (k < 34) cmd = CMD_RESUME;
            else if (k < 41) cmd = CMD_LOOKUP;
            else if (k < 56) cmd = CMD_EXEC;
            else if (k < 78) cmd = CMD_TICK;
            else if (k < 88) cmd = CMD_RUNTICK;
            else if (k < 92) cmd = CMD_SLEEP;
            else if (k < 97) cmd = CMD_SET_PERIOD;
            else cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            // never read the id of a slot that was never added
            if (cmd == CMD_DELETE && !sh_written[s]) cmd = CMD_ADD;
            send_word(cmd, s, id, t);
        end
        drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= CMD_ADD;
        s_slot <= '0;
        s_task_id <= '0;
        s_ticks <= '0;
        m_ready <= 1'b0;
        failed = 1'b0;
        src_idle = 14;
        snk_idle = 45;
        for (int i = 0; i < NSLOTS; i++) begin
            sh_state[i] = SS_DETACHED;
            sh_id[i] = '0;
            sh_period[i] = '0;
            sh_count[i] = '0;
            sh_ready[i] = 1'b0;
            sh_runt[i] = '0;
            sh_capt[i] = '0;
            sh_written[i] = 1'b0;
        end
        expired_valid = 1'b0;
        expired_slot = 0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'($urandom);
        id_pool[3] = 16'($urandom);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(150);
        src_idle = 45;
        snk_idle = 14;
        test_random(150);
        src_idle = 0;
        snk_idle = 0;
        test_random(150);

        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
